// File: src/psru_pkg.sv
package psru_pkg;

  localparam int unsigned BankCnt = 5;

  localparam logic [31:0] StatusReset = 32'h0000_00D3;
  localparam logic [31:0] ExcClear    = 32'h0000_00BF;
  localparam logic [31:0] UndSet      = 32'h0000_009B;
  localparam logic [31:0] SvcSet      = 32'h0000_0093;
  localparam logic [31:0] TbitKeep    = 32'hFFFF_FFDF;
  localparam logic [31:0] UserKeep    = 32'hFFFF_FF00;
  localparam logic [31:0] ForceBits   = 32'h0000_0010;
  localparam logic [4:0]  ModeUser    = 5'h10;
  localparam logic [4:0]  ModeSvc     = 5'h13;
  localparam logic [4:0]  ModeUnd     = 5'h1B;
  localparam logic [31:0] UndVecOfs   = 32'd4;
  localparam logic [31:0] SvcVecOfs   = 32'd8;
  localparam logic [31:0] ArmLinkOfs  = 32'd4;
  localparam logic [31:0] ThbLinkOfs  = 32'd2;

  typedef enum logic [2:0] {
    OP_MSR_IMM   = 3'd0,
    OP_MSR_REG   = 3'd1,
    OP_MRS       = 3'd2,
    OP_UND_ARM   = 3'd3,
    OP_UND_THUMB = 3'd4,
    OP_SVC_ARM   = 3'd5,
    OP_SVC_THUMB = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    BANK_FIQ = 3'd0,
    BANK_IRQ = 3'd1,
    BANK_SVC = 3'd2,
    BANK_ABT = 3'd3,
    BANK_UND = 3'd4
  } bank_e;

  typedef logic [BankCnt-1:0][31:0] spsr_arr_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] instr_word;
    logic [31:0] register_value;
    logic [31:0] pc_value;
  } item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        read_valid;
    logic [31:0] link_value;
    logic        take_exception;
    logic [31:0] vector_address;
    logic [31:0] current_status;
    logic        mode_changed;
  } result_t;

  // state update produced by one item
  typedef struct packed {
    logic [31:0] status;
    logic        spsr_we;
    bank_e       spsr_idx;
    logic [31:0] spsr_data;
  } upd_t;

endpackage

// File: src/psru_exec.sv
module psru_exec (
  input  psru_pkg::item_t   item_i,
  input  logic [31:0]       status_i,
  input  psru_pkg::spsr_arr_t spsr_i,
  input  logic [31:0]       vector_base_i,
  output psru_pkg::upd_t    upd_o,
  output psru_pkg::result_t res_o
);
  import psru_pkg::*;

  always_comb begin
    op_e         op;
    logic        saved_sel;
    logic        bank_hit;
    bank_e       bank;
    logic [31:0] mask;
    logic [31:0] imm_word;
    logic [63:0] imm_dbl;
    logic [4:0]  rot;
    logic [31:0] val;
    logic        is_svc;
    logic        thumb;

    op        = op_e'(item_i.opcode);
    saved_sel = item_i.instr_word[22];

    // bank lookup from current mode
    bank_hit = 1'b1;
    bank     = BANK_FIQ;
    unique case (status_i[4:0])
      5'h11: bank = BANK_FIQ;
      5'h12: bank = BANK_IRQ;
      5'h13: bank = BANK_SVC;
      5'h14, 5'h15, 5'h16, 5'h17: bank = BANK_ABT;
      5'h18, 5'h19, 5'h1A, 5'h1B: bank = BANK_UND;
      default: bank_hit = 1'b0;
    endcase

    // byte-field mask
    mask = {{8{item_i.instr_word[19]}}, {8{item_i.instr_word[18]}},
            {8{item_i.instr_word[17]}}, {8{item_i.instr_word[16]}}};
    if (!saved_sel) mask = mask & TbitKeep;
    if (status_i[4:0] == ModeUser) mask = mask & UserKeep;

    // rotated immediate, rotation is twice the 4-bit field
    imm_word = {24'd0, item_i.instr_word[7:0]};
    rot      = {item_i.instr_word[11:8], 1'b0};
    imm_dbl  = {imm_word, imm_word} >> rot;
    val      = (op == OP_MSR_IMM) ? imm_dbl[31:0] : item_i.register_value;
    val      = val | ForceBits;

    is_svc = (op == OP_SVC_ARM) || (op == OP_SVC_THUMB);
    thumb  = (op == OP_UND_THUMB) || (op == OP_SVC_THUMB);

    upd_o.status    = status_i;
    upd_o.spsr_we   = 1'b0;
    upd_o.spsr_idx  = bank;
    upd_o.spsr_data = (spsr_i[bank] & ~mask) | (val & mask);

    res_o.read_value     = '0;
    res_o.read_valid     = 1'b0;
    res_o.link_value     = '0;
    res_o.take_exception = 1'b0;
    res_o.vector_address = '0;

    case (op)
      OP_MSR_IMM, OP_MSR_REG: begin
        if (!saved_sel) begin
          upd_o.status = (status_i & ~mask) | (val & mask);
        end else begin
          upd_o.spsr_we = bank_hit;
        end
      end
      OP_MRS: begin
        res_o.read_value = (saved_sel && bank_hit) ? spsr_i[bank] : status_i;
        res_o.read_valid = 1'b1;
      end
      OP_UND_ARM, OP_UND_THUMB, OP_SVC_ARM, OP_SVC_THUMB: begin
        upd_o.status    = (status_i & ~ExcClear) | (is_svc ? SvcSet : UndSet);
        upd_o.spsr_we   = 1'b1;
        upd_o.spsr_idx  = is_svc ? BANK_SVC : BANK_UND;
        upd_o.spsr_data = status_i;
        res_o.link_value     = item_i.pc_value - (thumb ? ThbLinkOfs : ArmLinkOfs);
        res_o.take_exception = 1'b1;
        res_o.vector_address = vector_base_i + (is_svc ? SvcVecOfs : UndVecOfs);
      end
      default: ;
    endcase

    res_o.current_status = upd_o.status;
    res_o.mode_changed   = (upd_o.status[4:0] != status_i[4:0]);
  end

endmodule

// File: src/program_status_register_unit_core.sv
// pipeline: input register, then result register
// throughput: one item per cycle unless the result channel stalls; the status update
// sits between the two registers and is applied as the item moves into the result register
// reset: asynchronous active low; status word 0xd3 (svc mode, irq/fiq masked),
// all saved status words and the vector base cleared, both stages empty
module program_status_register_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] register_value_i,
  input  logic [31:0] pc_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic        read_valid_o,
  output logic [31:0] link_value_o,
  output logic        take_exception_o,
  output logic [31:0] vector_address_o,
  output logic [31:0] current_status_o,
  output logic        mode_changed_o
);
  import psru_pkg::*;

  // architectural state
  logic [31:0] vector_base_q;
  logic [31:0] status_q;
  spsr_arr_t   spsr_q;

  // input stage
  logic        s1_valid_q;
  item_t       s1_item_q;

  // result stage
  logic        out_valid_q;
  result_t     res_q;

  upd_t        upd;
  result_t     res_d;
  logic        advance;

  // item leaves the input register when the result register is free or drains
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  // input register accepts whenever it is empty or being emptied this cycle
  assign in_ready_o = !s1_valid_q || advance;

  psru_exec u_exec (
    .item_i        (s1_item_q),
    .status_i      (status_q),
    .spsr_i        (spsr_q),
    .vector_base_i (vector_base_q),
    .upd_o         (upd),
    .res_o         (res_d)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      vector_base_q <= '0;
      status_q      <= StatusReset;
      spsr_q        <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        vector_base_q <= cfg_wdata_i;
      end
      // state commits once per item, as it enters the result register
      if (advance) begin
        status_q <= upd.status;
        if (upd.spsr_we) begin
          spsr_q[upd.spsr_idx] <= upd.spsr_data;
        end
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q.opcode         <= opcode_i;
      s1_item_q.instr_word     <= instr_word_i;
      s1_item_q.register_value <= register_value_i;
      s1_item_q.pc_value       <= pc_value_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = res_q.read_value;
  assign read_valid_o     = res_q.read_valid;
  assign link_value_o     = res_q.link_value;
  assign take_exception_o = res_q.take_exception;
  assign vector_address_o = res_q.vector_address;
  assign current_status_o = res_q.current_status;
  assign mode_changed_o   = res_q.mode_changed;

`ifndef SYNTH
  // exception entry always lands in svc or undefined mode
  a_exc_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && take_exception_o) |->
      (current_status_o[4:0] == ModeSvc || current_status_o[4:0] == ModeUnd))
    else $error("exception result with wrong mode");

  // a read and an exception never come from the same transfer
  a_read_xor_exc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(read_valid_o && take_exception_o))
    else $error("read and exception flagged together");

  // bit 4 of the status word is forced on by every update
  a_bit4_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q[4])
    else $error("status bit 4 cleared");

  // state only moves with an item
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(status_q) && $stable(spsr_q))
    else $error("status changed without an item");

  // a stalled input stage means an item is held
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");
`endif

endmodule
